@@ design/wsd_pkg.sv @@
// ----------------------------------------------------------------------------
// wsd_pkg: shared types and constants for the websocket frame deframer
// parse phases, result kinds and the result record used across modules
// ----------------------------------------------------------------------------
package wsd_pkg;

   localparam int unsigned WSD_LENGTH_BITS = 64;
   localparam int unsigned WSD_LEN_OUT_W   = 63;

   localparam logic [7:0] WSD_FIN_BIT     = 8'b1000_0000;
   localparam logic [7:0] WSD_OPCODE_MASK = 8'b0000_1111;
   localparam logic [7:0] WSD_LEN7_MASK   = 8'b0111_1111;
   localparam logic [6:0] WSD_LEN7_EXT16  = 7'd126;
   localparam logic [6:0] WSD_LEN7_EXT64  = 7'd127;
   localparam logic [3:0] WSD_EXT16_BYTES = 4'd2;
   localparam logic [3:0] WSD_EXT64_BYTES = 4'd8;
   localparam logic [3:0] WSD_KEY_LAST    = 4'd3;

   typedef enum logic [2:0] {
      PH_BYTE0   = 3'd0,
      PH_BYTE1   = 3'd1,
      PH_EXTLEN  = 3'd2,
      PH_MASKKEY = 3'd3,
      PH_PAYLOAD = 3'd4
   } phase_type;

   typedef enum logic [1:0] {
      KIND_HEADER  = 2'd0,
      KIND_PAYLOAD = 2'd1,
      KIND_ERROR   = 2'd2
   } result_kind_type;

   typedef struct packed {
      result_kind_type            kind;
      logic                       fin_flag;
      logic [3:0]                 opcode;
      logic [WSD_LEN_OUT_W-1:0]   payload_length;
      logic [7:0]                 data_byte;
      logic                       last_byte;
   } result_type;

endpackage

@@ design/wsd_req_if.sv @@
// ----------------------------------------------------------------------------
// wsd_req_if: received byte channel
// valid/ready handshake carrying one stream byte per beat
// ----------------------------------------------------------------------------
interface wsd_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] rx_byte;

   modport source (output valid, output rx_byte, input ready);
   modport sink   (input valid, input rx_byte, output ready);
endinterface

@@ design/wsd_rsp_if.sv @@
// ----------------------------------------------------------------------------
// wsd_rsp_if: deframer result channel
// valid/ready handshake carrying one header, payload or error result per beat
// ----------------------------------------------------------------------------
interface wsd_rsp_if;
   import wsd_pkg::*;

   logic                     valid;
   logic                     ready;
   logic [1:0]               result_kind;
   logic                     fin_flag;
   logic [3:0]               opcode;
   logic [WSD_LEN_OUT_W-1:0] payload_length;
   logic [7:0]               data_byte;
   logic                     last_byte;

   modport source (output valid, output result_kind, output fin_flag, output opcode,
                   output payload_length, output data_byte, output last_byte,
                   input ready);
   modport sink   (input valid, input result_kind, input fin_flag, input opcode,
                   input payload_length, input data_byte, input last_byte,
                   output ready);
endinterface

@@ design/wsd_parser.sv @@
// ----------------------------------------------------------------------------
// wsd_parser: frame header parser and payload unmasker
// holds the frame state, advances one byte per accepted beat and forms the
// result for that byte
// ----------------------------------------------------------------------------
module wsd_parser #(
   parameter int unsigned LENGTH_BITS = wsd_pkg::WSD_LENGTH_BITS
) (
   input  logic                clock,
   input  logic                reset,
   input  logic                accept,
   input  logic [7:0]          rx_byte,
   output logic                res_valid,
   output wsd_pkg::result_type res
);
   import wsd_pkg::*;

   // bit 63 is reserved, so at most 63 length bits are kept
   localparam int unsigned LenW = (LENGTH_BITS >= 63) ? 63 : LENGTH_BITS;

   phase_type        phase_ff, phase_in;
   logic             fin_ff, fin_in;
   logic [3:0]       opcode_ff, opcode_in;
   logic [LenW-1:0]  length_ff, length_in;
   logic [3:0]       count_ff, count_in;
   logic             ext_long_ff, ext_long_in;
   logic [31:0]      key_ff, key_in;
   logic [LenW-1:0]  remaining_ff, remaining_in;

   logic [6:0]       len7;
   logic [3:0]       count_inc;
   logic [3:0]       ext_needed;
   logic             ext_done;
   logic             key_done;
   logic             length_zero;
   logic             payload_last;

   assign len7         = rx_byte[6:0] & WSD_LEN7_MASK[6:0];
   assign count_inc    = count_ff + 4'd1;
   assign ext_needed   = ext_long_ff ? WSD_EXT64_BYTES : WSD_EXT16_BYTES;
   assign ext_done     = (count_inc == ext_needed);
   assign key_done     = (count_ff == WSD_KEY_LAST);
   assign length_zero  = (length_ff == '0);
   assign payload_last = (remaining_ff == LenW'(1));

   // next phase
   always_comb begin
      phase_in = phase_ff;
      unique case (phase_ff)
         PH_BYTE0: begin
            phase_in = PH_BYTE1;
         end
         PH_BYTE1: begin
            if ((rx_byte & WSD_FIN_BIT) == 8'd0) begin
               phase_in = PH_BYTE0;
            end else if (len7 == WSD_LEN7_EXT16 || len7 == WSD_LEN7_EXT64) begin
               phase_in = PH_EXTLEN;
            end else begin
               phase_in = PH_MASKKEY;
            end
         end
         PH_EXTLEN: begin
            if (ext_done) begin
               phase_in = PH_MASKKEY;
            end
         end
         PH_MASKKEY: begin
            if (key_done) begin
               phase_in = length_zero ? PH_BYTE0 : PH_PAYLOAD;
            end
         end
         PH_PAYLOAD: begin
            if (payload_last) begin
               phase_in = PH_BYTE0;
            end
         end
         default: begin
            phase_in = PH_BYTE0;
         end
      endcase
   end

   // datapath and result
   always_comb begin
      fin_in       = fin_ff;
      opcode_in    = opcode_ff;
      length_in    = length_ff;
      count_in     = count_ff;
      ext_long_in  = ext_long_ff;
      key_in       = key_ff;
      remaining_in = remaining_ff;

      res_valid          = 1'b0;
      res.kind           = KIND_HEADER;
      res.fin_flag       = fin_ff;
      res.opcode         = opcode_ff;
      res.payload_length = '0;
      res.data_byte      = 8'd0;
      res.last_byte      = 1'b0;

      unique case (phase_ff)
         PH_BYTE0: begin
            fin_in    = (rx_byte & WSD_FIN_BIT) != 8'd0;
            opcode_in = rx_byte[3:0] & WSD_OPCODE_MASK[3:0];
         end
         PH_BYTE1: begin
            if ((rx_byte & WSD_FIN_BIT) == 8'd0) begin
               res_valid = 1'b1;
               res.kind  = KIND_ERROR;
            end else begin
               count_in    = 4'd0;
               ext_long_in = (len7 == WSD_LEN7_EXT64);
               key_in      = 32'd0;
               if (len7 == WSD_LEN7_EXT16 || len7 == WSD_LEN7_EXT64) begin
                  length_in = '0;
               end else begin
                  length_in = LenW'(len7);
               end
            end
         end
         PH_EXTLEN: begin
            // big-endian: each byte shifts in at the bottom
            length_in = {length_ff[LenW-9:0], rx_byte};
            count_in  = ext_done ? 4'd0 : count_inc;
         end
         PH_MASKKEY: begin
            key_in   = {key_ff[23:0], rx_byte};
            count_in = key_done ? 4'd0 : count_inc;
            if (key_done) begin
               res_valid          = 1'b1;
               res.kind           = KIND_HEADER;
               res.payload_length = WSD_LEN_OUT_W'(length_ff);
               res.last_byte      = length_zero;
               remaining_in       = length_ff;
            end
         end
         PH_PAYLOAD: begin
            // key rotates so the byte for the current index sits on top
            key_in        = {key_ff[23:0], key_ff[31:24]};
            remaining_in  = remaining_ff - LenW'(1);
            res_valid     = 1'b1;
            res.kind      = KIND_PAYLOAD;
            res.data_byte = rx_byte ^ key_ff[31:24];
            res.last_byte = payload_last;
         end
         default: begin
            res_valid = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff     <= PH_BYTE0;
         fin_ff       <= 1'b0;
         opcode_ff    <= 4'd0;
         length_ff    <= '0;
         count_ff     <= 4'd0;
         ext_long_ff  <= 1'b0;
         key_ff       <= 32'd0;
         remaining_ff <= '0;
      end else if (accept) begin
         phase_ff     <= phase_in;
         fin_ff       <= fin_in;
         opcode_ff    <= opcode_in;
         length_ff    <= length_in;
         count_ff     <= count_in;
         ext_long_ff  <= ext_long_in;
         key_ff       <= key_in;
         remaining_ff <= remaining_in;
      end
   end

endmodule

@@ design/websocket_frame_deframer.sv @@
// ----------------------------------------------------------------------------
// websocket_frame_deframer: receive-side websocket frame parser
// parses frame headers from a byte stream and unmasks payload bytes
// ----------------------------------------------------------------------------
//  channel   dir  handshake      payload
//  req_bus   in   valid/ready    rx_byte
//  rsp_bus   out  valid/ready    result_kind, fin_flag, opcode,
//                                payload_length, data_byte, last_byte
//
//  one byte per cycle unless stalled; a beat is parsed in the cycle
//  it is accepted; its result, if any, is in the output register next cycle
//  req_bus.ready is high while the output register is empty or being taken
//  synchronous reset returns the parser to waiting for byte 0 of a frame
// ----------------------------------------------------------------------------
module websocket_frame_deframer #(
   parameter int unsigned LENGTH_BITS = wsd_pkg::WSD_LENGTH_BITS
) (
   input  logic      clock,
   input  logic      reset,
   wsd_req_if.sink   req_bus,
   wsd_rsp_if.source rsp_bus
);
   import wsd_pkg::*;

   logic       accept;
   logic       res_valid;
   result_type res;

   logic       rsp_valid_ff, rsp_valid_in;
   result_type rsp_ff, rsp_in;

   assign req_bus.ready = !rsp_valid_ff || rsp_bus.ready;
   assign accept        = req_bus.valid && req_bus.ready;

   wsd_parser #(
      .LENGTH_BITS (LENGTH_BITS)
   ) u_parser (
      .clock     (clock),
      .reset     (reset),
      .accept    (accept),
      .rx_byte   (req_bus.rx_byte),
      .res_valid (res_valid),
      .res       (res)
   );

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      if (accept) begin
         rsp_valid_in = res_valid;
         rsp_in       = res;
      end else if (rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_bus.valid          = rsp_valid_ff;
   assign rsp_bus.result_kind    = rsp_ff.kind;
   assign rsp_bus.fin_flag       = rsp_ff.fin_flag;
   assign rsp_bus.opcode         = rsp_ff.opcode;
   assign rsp_bus.payload_length = rsp_ff.payload_length;
   assign rsp_bus.data_byte      = rsp_ff.data_byte;
   assign rsp_bus.last_byte      = rsp_ff.last_byte;

   // error results carry only the byte 0 fields
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_ERROR) |->
         (rsp_ff.payload_length == '0 && rsp_ff.data_byte == 8'd0 && !rsp_ff.last_byte))
      else $error("error result carries length, data or last");

   // a header is marked last exactly when its length is zero
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_HEADER) |->
         (rsp_ff.last_byte == (rsp_ff.payload_length == '0)))
      else $error("header last flag disagrees with length");

   // a beat that makes no result leaves the output empty
   assert property (@(posedge clock) disable iff (reset)
      (accept && !res_valid) |=> !rsp_valid_ff)
      else $error("result appeared for a beat that makes none");

   // payload results never carry a length
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && rsp_ff.kind == KIND_PAYLOAD) |-> rsp_ff.payload_length == '0)
      else $error("payload result carries a length");

endmodule
